// ===== hw/rtl/scta_pkg.sv =====
`timescale 1ns / 1ps
package scta_pkg;

    localparam int IP_W     = 32;
    localparam int PREFIX_W = 6;
    localparam int IFACE_W  = 16;

    typedef struct packed {
        logic [IFACE_W-1:0]  iface;
        logic [PREFIX_W-1:0] prefix;
        logic [IP_W-1:0]     ip;
    } entry_t;

    // one cell's state as handed to a neighbor
    typedef struct packed {
        logic   used;
        logic   hit;
        entry_t data;
    } cell_link_t;

    typedef logic [1:0] cell_op_t;
    localparam cell_op_t CELL_HOLD = 2'd0;
    localparam cell_op_t CELL_PREV = 2'd1;
    localparam cell_op_t CELL_NEXT = 2'd2;
    localparam cell_op_t CELL_EVAL = 2'd3;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_FIND   = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND   = 2'd1;
    localparam logic [1:0] ST_FULL        = 2'd2;
    localparam logic [1:0] ST_NO_CONFLICT = 2'd3;

    function automatic logic [IP_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] p);
        logic [IP_W-1:0] m;
        if (p == '0)
            m = '0;
        else if (p >= PREFIX_W'(IP_W))
            m = '1;
        else
            m = ~({IP_W{1'b1}} >> p);
        return m;
    endfunction

endpackage

// ===== hw/rtl/scta_cell.sv =====
`timescale 1ns / 1ps
module scta_cell
    import scta_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_op_t   op,
    input  entry_t     query,
    input  cell_link_t prev_link,
    input  cell_link_t next_link,
    output cell_link_t link,
    output logic       del_match
);

    logic            used_reg;
    logic            hit_reg;
    entry_t          data_reg;
    logic [IP_W-1:0] m_own;
    logic [IP_W-1:0] m_q;
    logic [IP_W-1:0] s_own;
    logic [IP_W-1:0] e_own;
    logic [IP_W-1:0] s_q;
    logic [IP_W-1:0] e_q;
    logic            overlap;
    logic            hit_next;

    assign m_own   = prefix_mask(data_reg.prefix);
    assign m_q     = prefix_mask(query.prefix);
    assign s_own   = data_reg.ip & m_own;
    assign e_own   = s_own | ~m_own;
    assign s_q     = query.ip & m_q;
    assign e_q     = s_q | ~m_q;
    assign overlap = (s_own <= e_q) && (s_q <= e_own);
    assign hit_next = used_reg && (data_reg.iface != query.iface) && overlap;

    assign del_match = used_reg && (data_reg == query);
    assign link      = '{used: used_reg, hit: hit_reg, data: data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            case (op)
                CELL_PREV:
                begin
                    used_reg <= prev_link.used;
                    hit_reg  <= prev_link.hit;
                end
                CELL_NEXT:
                begin
                    used_reg <= next_link.used;
                    hit_reg  <= 1'b0;
                end
                CELL_EVAL:
                begin
                    hit_reg <= hit_next;
                end
                default:
                begin
                    used_reg <= used_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            CELL_PREV: data_reg <= prev_link.data;
            CELL_NEXT: data_reg <= next_link.data;
            default:   data_reg <= data_reg;
        endcase
    end

endmodule

// ===== hw/rtl/subnet_conflict_table_unit.sv =====
`timescale 1ns / 1ps
// Timing: insert, delete and unused codes give their single beat, registered from the EXEC state.
// A find passes EXEC and CHECK and its first beat is registered from CHECK; it then walks the ring of
// TABLE_DEPTH cells, one cell per cycle through the tail while no hit at the tail waits on the output;
// only a find with conflicts holds the unit for the walk, and every code also waits on output stalls.
// Reset (rst_n low, asynchronous): table empty, no beat pending, unit idle.
module subnet_conflict_table_unit
    import scta_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int IFACE_BITS  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // addr_ip[31:0], prefix_len[37:32], iface[53:38], zero
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // hit_ip[31:0], hit_prefix[37:32], hit_iface[53:38], zero
    output logic [2:0]  m_tuser,   // status[1:0], hit_valid[2]
    output logic        m_tlast
);

    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int SCW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IFACE_W-1:0] IFACE_MASK =
        (IFACE_BITS >= IFACE_W) ? {IFACE_W{1'b1}}
                                : IFACE_W'((17'd1 << IFACE_BITS) - 17'd1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_SCAN  = 2'd3;

    logic [1:0]     state_reg, state_next;
    logic [1:0]     func_reg;
    entry_t         query_reg;
    logic [CW-1:0]  count_reg, count_next;
    logic [SCW-1:0] step_reg, step_next;

    logic           out_valid_reg;
    logic [1:0]     out_status_reg, out_status_next;
    logic           out_hv_reg, out_hv_next;
    entry_t         out_data_reg, out_data_next;
    logic           out_last_reg, out_last_next;
    logic           load_out;

    cell_link_t     links [TABLE_DEPTH];
    cell_link_t     head_link;
    cell_link_t     tail_link;
    cell_op_t       common_op;
    logic           del_mode;
    logic [TABLE_DEPTH-1:0] match_vec;
    logic [TABLE_DEPTH-1:0] shift_vec;
    logic [TABLE_DEPTH-1:0] hit_vec;
    logic [TABLE_DEPTH-1:0] used_vec;
    logic           others_hit;
    logic           can_load;
    logic           s_accept;
    logic           full;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign can_load  = !out_valid_reg || m_tready;
    assign tail_link = links[TABLE_DEPTH-1];
    assign full      = (count_reg >= CW'(TABLE_DEPTH));

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            cell_link_t prev_l;
            cell_link_t next_l;
            cell_op_t   op_l;

            if (gi == 0)
            begin : g_head
                assign prev_l = head_link;
            end
            else
            begin : g_mid
                assign prev_l = links[gi-1];
            end

            if (gi == TABLE_DEPTH - 1)
            begin : g_tail
                assign next_l = '0;
            end
            else
            begin : g_body
                assign next_l = links[gi+1];
            end

            assign shift_vec[gi] = |match_vec[gi:0];
            assign op_l = del_mode ? (shift_vec[gi] ? CELL_NEXT : CELL_HOLD) : common_op;
            assign hit_vec[gi]  = links[gi].hit;
            assign used_vec[gi] = links[gi].used;

            scta_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .op        (op_l),
                .query     (query_reg),
                .prev_link (prev_l),
                .next_link (next_l),
                .link      (links[gi]),
                .del_match (match_vec[gi])
            );
        end

        if (TABLE_DEPTH > 1)
        begin : g_oth
            assign others_hit = |hit_vec[TABLE_DEPTH-2:0];
        end
        else
        begin : g_one
            assign others_hit = 1'b0;
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        common_op       = CELL_HOLD;
        del_mode        = 1'b0;
        head_link       = '{used: tail_link.used, hit: 1'b0, data: tail_link.data};
        load_out        = 1'b0;
        out_status_next = ST_OK;
        out_hv_next     = 1'b0;
        out_data_next   = '0;
        out_last_next   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (func_reg == FUNC_FIND)
                begin
                    common_op  = CELL_EVAL;
                    state_next = S_CHECK;
                end
                else if (can_load)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                    case (func_reg)
                        FUNC_INSERT:
                        begin
                            if (full)
                                out_status_next = ST_FULL;
                            else
                            begin
                                common_op  = CELL_PREV;
                                head_link  = '{used: 1'b1, hit: 1'b0, data: query_reg};
                                count_next = count_reg + CW'(1);
                            end
                        end
                        FUNC_DELETE:
                        begin
                            if (|match_vec)
                            begin
                                del_mode   = 1'b1;
                                count_next = count_reg - CW'(1);
                            end
                            else
                                out_status_next = ST_NOT_FOUND;
                        end
                        default:
                        begin
                            out_status_next = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                if (can_load)
                begin
                    load_out = 1'b1;
                    if (|hit_vec)
                    begin
                        out_hv_next   = 1'b1;
                        out_data_next = query_reg;
                        out_last_next = 1'b0;
                        step_next     = '0;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        out_status_next = ST_NO_CONFLICT;
                        state_next      = S_IDLE;
                    end
                end
            end
            S_SCAN:
            begin
                if (!tail_link.hit || can_load)
                begin
                    common_op = CELL_PREV;
                    if (tail_link.hit)
                    begin
                        load_out      = 1'b1;
                        out_hv_next   = 1'b1;
                        out_data_next = tail_link.data;
                        out_last_next = !others_hit;
                    end
                    step_next = step_reg + SCW'(1);
                    if (step_reg == SCW'(TABLE_DEPTH - 1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            func_reg        <= s_tuser;
            query_reg.ip     <= s_tdata[31:0];
            query_reg.prefix <= s_tdata[37:32];
            query_reg.iface  <= s_tdata[53:38] & IFACE_MASK;
        end
        if (load_out)
        begin
            out_status_reg <= out_status_next;
            out_hv_reg     <= out_hv_next;
            out_data_reg   <= out_data_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg.iface, out_data_reg.prefix, out_data_reg.ip};
    assign m_tuser  = {out_hv_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_vec) == int'(count_reg))
        else $error("used cells disagree with entry count");

    a_idle_no_hits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> hit_vec == '0)
        else $error("hit flags left set after a find");

    a_scan_rotates: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && !tail_link.hit) |=> step_reg == $past(step_reg) + SCW'(1))
        else $error("scan stalled without a pending beat");

endmodule
